@@ design/assert_macros.svh @@
// assertion macros used by the top level rtl file
// no dependencies; checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HMMP_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error("check failed");
`define HMMP_NEVER(lbl, ck, rstn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(expr)) else $error("never failed");
`else
`define HMMP_ASSERT(lbl, ck, rstn, prop)
`define HMMP_NEVER(lbl, ck, rstn, expr)
`endif
`endif

@@ design/hmmp_pkg.sv @@
// shared types, constants and geometry functions for the height pyramid block
// no dependencies
package hmmp_pkg;

  localparam int CHUNK_CELLS   = 16;
  localparam int REGION_CHUNKS = 8;
  localparam int REGION_LEVELS = 4;
  localparam int CHUNK_LEVELS  = 2;
  localparam int ALL_LEVELS    = REGION_LEVELS + CHUNK_LEVELS;
  localparam int GRID_SIDE     = REGION_CHUNKS * CHUNK_CELLS;
  localparam int WIN_SIDE      = GRID_SIDE + 3;

  // side of pyramid level l in cells
  function automatic int grid_side(int l);
    if (l < REGION_LEVELS) return (REGION_CHUNKS >> l) * CHUNK_CELLS;
    return CHUNK_CELLS >> (l - REGION_LEVELS + 1);
  endfunction

  // start of level l (l >= 1) in the pyramid store
  function automatic int pyr_offset(int l);
    int off;
    int s;
    off = 0;
    for (int k = 1; k < ALL_LEVELS; k++) begin
      s = grid_side(k);
      if (k < l) off += s * s;
    end
    return off;
  endfunction

  function automatic int nodes_side(int l);
    return REGION_CHUNKS >> l;
  endfunction

  function automatic int bnd_offset(int l);
    int off;
    int s;
    off = 0;
    for (int k = 0; k < REGION_LEVELS; k++) begin
      s = nodes_side(k);
      if (k < l) off += s * s;
    end
    return off;
  endfunction

  function automatic int aw_of(int d);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  localparam int WIN_DEPTH = WIN_SIDE * WIN_SIDE;
  localparam int PYR_DEPTH = max2(1, pyr_offset(ALL_LEVELS));
  localparam int BND_DEPTH = max2(1, bnd_offset(REGION_LEVELS));
  localparam int WIN_AW    = aw_of(WIN_DEPTH);
  localparam int PYR_AW    = aw_of(PYR_DEPTH);
  localparam int BND_AW    = aw_of(BND_DEPTH);
  localparam int ADDR_W    = max2(PYR_AW, BND_AW);
  localparam int CRD_W     = $clog2(WIN_SIDE + 1);
  localparam int SMP_W     = 8;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_HEIGHT = 2'd2;
  localparam logic [1:0] REQ_BOUNDS = 2'd3;

  localparam logic MODE_PYR = 1'b0;
  localparam logic MODE_BND = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] level;
    logic [7:0] pos_x;
    logic [7:0] pos_z;
    logic [7:0] sample;
  } hmmp_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] height_out;
    logic [7:0] min_out;
    logic [7:0] max_out;
  } hmmp_rsp_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic       mode;
    logic [2:0] lvl;
  } hmmp_cmd_t;

  typedef struct packed {
    logic last;
    logic empty;
  } hmmp_sts_t;

endpackage

@@ design/hmmp_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies beyond the package defaults
module hmmp_ram #(
  parameter int DW    = hmmp_pkg::SMP_W,
  parameter int DEPTH = hmmp_pkg::WIN_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                         wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                         rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ design/hmmp_ctrl.sv @@
// build sequencer: walks pyramid levels then bounds levels
// depends on hmmp_pkg
module hmmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hmmp_pkg::hmmp_sts_t sts,
  output hmmp_pkg::hmmp_cmd_t cmd,
  output logic                busy
);
  import hmmp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       mode_r, mode_nxt;
  logic [2:0] lvl_r, lvl_nxt;
  logic       adv_mode, adv_done;
  logic [2:0] adv_lvl;

  // next level in build order
  always_comb begin
    adv_mode = mode_r;
    adv_lvl  = lvl_r;
    adv_done = 1'b0;
    if (mode_r == MODE_PYR) begin
      if (int'(lvl_r) + 1 < ALL_LEVELS) begin
        adv_lvl = lvl_r + 3'd1;
      end else begin
        adv_mode = MODE_BND;
        adv_lvl  = 3'd0;
      end
    end else begin
      if (int'(lvl_r) + 1 < REGION_LEVELS) adv_lvl = lvl_r + 3'd1;
      else adv_done = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    lvl_nxt   = lvl_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SETUP;
          if (ALL_LEVELS > 1) begin
            mode_nxt = MODE_PYR;
            lvl_nxt  = 3'd1;
          end else begin
            mode_nxt = MODE_BND;
            lvl_nxt  = 3'd0;
          end
        end
      end
      S_SETUP: begin
        if (sts.empty) begin
          mode_nxt  = adv_mode;
          lvl_nxt   = adv_lvl;
          state_nxt = adv_done ? S_FLUSH : S_SETUP;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.last) begin
          mode_nxt  = adv_mode;
          lvl_nxt   = adv_lvl;
          state_nxt = adv_done ? S_FLUSH : S_SETUP;
        end
      end
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_PYR;
      lvl_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  assign cmd.init = (state_r == S_SETUP);
  assign cmd.step = (state_r == S_RUN);
  assign cmd.mode = mode_r;
  assign cmd.lvl  = lvl_r;
  assign busy     = (state_r != S_IDLE);
endmodule

@@ design/hmmp_dp.sv @@
// build datapath: cell and tap counters, store addressing, sum and min/max
// depends on hmmp_pkg
module hmmp_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hmmp_pkg::hmmp_cmd_t             cmd,
  output hmmp_pkg::hmmp_sts_t             sts,
  output logic                            win_re,
  output logic [hmmp_pkg::WIN_AW-1:0]     win_raddr,
  input  logic [7:0]                      win_rdata,
  output logic                            pyr_re,
  output logic [hmmp_pkg::PYR_AW-1:0]     pyr_raddr,
  input  logic [7:0]                      pyr_rdata,
  output logic                            pyr_we,
  output logic [hmmp_pkg::PYR_AW-1:0]     pyr_waddr,
  output logic [7:0]                      pyr_wdata,
  output logic                            bnd_re,
  output logic [hmmp_pkg::BND_AW-1:0]     bnd_raddr,
  input  logic [15:0]                     bnd_rdata,
  output logic                            bnd_we,
  output logic [hmmp_pkg::BND_AW-1:0]     bnd_waddr,
  output logic [15:0]                     bnd_wdata
);
  import hmmp_pkg::*;

  localparam int IW = $clog2(CHUNK_CELLS + 3);
  localparam logic [1:0] SRC_WIN = 2'd0;
  localparam logic [1:0] SRC_PYR = 2'd1;
  localparam logic [1:0] SRC_BND = 2'd2;

  logic [CRD_W-1:0]  x_r, z_r;
  logic [IW-1:0]     i_r, j_r;
  logic [9:0]        sum_r;
  logic [7:0]        lo_r, hi_r;
  logic              dv_r, dfirst_r, dlast_r, dok_r, dmode_r;
  logic [1:0]        dsel_r;
  logic [ADDR_W-1:0] dst_r;

  int                lv, lvm1, side, pside, prow, pcol, src, dst;
  logic [IW-1:0]     lim;
  logic              i_last, j_last, x_last, z_last, ok;
  logic [1:0]        sel;
  logic [7:0]        h, lo_c, hi_c, lo_b, hi_b, lo_n, hi_n;
  logic [9:0]        sum_n, sum_rnd;

  // tap source and cell destination
  always_comb begin
    lv    = int'(cmd.lvl);
    lvm1  = (lv > 0) ? lv - 1 : 0;
    side  = (cmd.mode == MODE_PYR) ? grid_side(lv) : nodes_side(lv);
    lim   = (cmd.mode == MODE_BND && cmd.lvl == 3'd0) ? IW'(CHUNK_CELLS + 2) : IW'(1);
    prow  = 2 * int'(z_r) + int'(j_r);
    pcol  = 2 * int'(x_r) + int'(i_r);
    ok    = 1'b1;
    sel   = SRC_WIN;
    src   = 0;
    if (cmd.mode == MODE_PYR) begin
      pside = grid_side(lvm1);
      ok    = (pcol < pside) && (prow < pside);
      if (lv == 1) begin
        src = (prow + 1) * WIN_SIDE + pcol + 1;
      end else begin
        sel = SRC_PYR;
        src = pyr_offset(lvm1) + prow * pside + pcol;
      end
      dst = pyr_offset(lv) + int'(z_r) * side + int'(x_r);
    end else begin
      pside = nodes_side(lvm1);
      if (lv == 0) begin
        src = (int'(z_r) * CHUNK_CELLS + int'(j_r)) * WIN_SIDE
            + int'(x_r) * CHUNK_CELLS + int'(i_r);
      end else begin
        sel = SRC_BND;
        src = bnd_offset(lvm1) + prow * pside + pcol;
      end
      dst = bnd_offset(lv) + int'(z_r) * side + int'(x_r);
    end
    i_last = (i_r == lim);
    j_last = (j_r == lim);
    x_last = (int'(x_r) == side - 1);
    z_last = (int'(z_r) == side - 1);
  end

  assign sts.last  = i_last && j_last && x_last && z_last;
  assign sts.empty = (side == 0);

  assign win_re    = cmd.step && ok && (sel == SRC_WIN);
  assign pyr_re    = cmd.step && ok && (sel == SRC_PYR);
  assign bnd_re    = cmd.step && ok && (sel == SRC_BND);
  assign win_raddr = WIN_AW'(src);
  assign pyr_raddr = PYR_AW'(src);
  assign bnd_raddr = BND_AW'(src);

  // counters: taps innermost, then columns, then rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      z_r <= '0;
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.init) begin
      x_r <= '0;
      z_r <= '0;
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.step) begin
      if (!i_last) begin
        i_r <= i_r + IW'(1);
      end else begin
        i_r <= '0;
        if (!j_last) begin
          j_r <= j_r + IW'(1);
        end else begin
          j_r <= '0;
          if (!x_last) begin
            x_r <= x_r + CRD_W'(1);
          end else begin
            x_r <= '0;
            z_r <= z_r + CRD_W'(1);
          end
        end
      end
    end
  end

  // tap data arrives in the cycle after its read
  always_comb begin
    h     = dok_r ? ((dsel_r == SRC_WIN) ? win_rdata : pyr_rdata) : 8'd0;
    lo_c  = (dsel_r == SRC_BND) ? bnd_rdata[7:0] : h;
    hi_c  = (dsel_r == SRC_BND) ? bnd_rdata[15:8] : h;
    lo_b  = dfirst_r ? 8'hff : lo_r;
    hi_b  = dfirst_r ? 8'h00 : hi_r;
    lo_n  = (lo_c < lo_b) ? lo_c : lo_b;
    hi_n  = (hi_c > hi_b) ? hi_c : hi_b;
    sum_n = (dfirst_r ? 10'd0 : sum_r) + {2'b00, h};
    sum_rnd = sum_n + 10'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else begin
      dv_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      dfirst_r <= (i_r == '0) && (j_r == '0);
      dlast_r  <= i_last && j_last;
      dok_r    <= ok;
      dsel_r   <= sel;
      dmode_r  <= cmd.mode;
      dst_r    <= ADDR_W'(dst);
    end
    if (dv_r) begin
      sum_r <= sum_n;
      lo_r  <= lo_n;
      hi_r  <= hi_n;
    end
  end

  assign pyr_we    = dv_r && dlast_r && (dmode_r == MODE_PYR);
  assign bnd_we    = dv_r && dlast_r && (dmode_r == MODE_BND);
  assign pyr_waddr = dst_r[PYR_AW-1:0];
  assign bnd_waddr = dst_r[BND_AW-1:0];
  assign pyr_wdata = sum_rnd[9:2];
  assign bnd_wdata = {hi_n, lo_n};
endmodule

@@ design/heightmap_mip_minmax_pyramid_top.sv @@
// top level of the height pyramid and min/max quadtree block
// depends on hmmp_pkg, hmmp_ram, hmmp_ctrl, hmmp_dp and assert_macros.svh
//
// usage
// - input channel in_valid / in_stall / in_data carries one request per beat:
//   load a window sample, build, read a pyramid cell or read a node's bounds
// - output channel out_valid / out_stall / out_data returns exactly one
//   response beat per request, in request order
// - loads and reads go one per cycle while in_stall is low; a response
//   passes the registered ram read in the read stage, then the output
//   register, before it shows on out_valid
// - a build answers at once with status ok, then holds in_stall high while
//   the sequencer walks the stores: one ram read per cycle, over a 2x2 tap
//   window per pyramid cell and per upper node and a (CHUNK_CELLS+3)^2
//   window per chunk bounds node, with a setup state before each level
// - when the receiver stalls, the output register holds, one more response
//   waits in the read stage, and then in_stall rises until out drains
// - reset clears the control state only; the stores are not cleared and
//   hold garbage until loaded or built
`include "assert_macros.svh"
module heightmap_mip_minmax_pyramid_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hmmp_pkg::hmmp_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hmmp_pkg::hmmp_rsp_t  out_data
);
  import hmmp_pkg::*;

  // what the read stage returns
  localparam logic [1:0] K_ZERO = 2'd0;
  localparam logic [1:0] K_WIN  = 2'd1;
  localparam logic [1:0] K_PYR  = 2'd2;
  localparam logic [1:0] K_BND  = 2'd3;

  hmmp_cmd_t cmd;
  hmmp_sts_t sts;
  logic      busy;

  // host side decode
  logic acc, start, mv;
  int   lv_i, px_i, pz_i, h_side, n_side;
  logic load_ok, hrd_ok, brd_ok;
  logic [1:0] kind;
  logic       err;
  logic       host_win_we, host_win_re, host_pyr_re, host_bnd_re;
  logic [WIN_AW-1:0] host_win_waddr, host_win_raddr;
  logic [PYR_AW-1:0] host_pyr_raddr;
  logic [BND_AW-1:0] host_bnd_raddr;

  // build side ram ports
  logic              dp_win_re, dp_pyr_re, dp_bnd_re;
  logic [WIN_AW-1:0] dp_win_raddr;
  logic [PYR_AW-1:0] dp_pyr_raddr, pyr_waddr;
  logic [BND_AW-1:0] dp_bnd_raddr, bnd_waddr;
  logic              pyr_we, bnd_we;
  logic [7:0]        pyr_wdata;
  logic [15:0]       bnd_wdata;

  logic [7:0]  win_rdata, pyr_rdata;
  logic [15:0] bnd_rdata;

  // read stage and output register
  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_kind_r;
  logic       s1_err_r;
  logic       out_v_r, out_v_nxt;
  hmmp_rsp_t  out_r, rsp;

  assign mv       = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = busy || (s1_v_r && !mv);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    lv_i    = int'(in_data.level);
    px_i    = int'(in_data.pos_x);
    pz_i    = int'(in_data.pos_z);
    h_side  = (lv_i < ALL_LEVELS) ? grid_side(lv_i) : 0;
    n_side  = (lv_i < REGION_LEVELS) ? nodes_side(lv_i) : 0;
    load_ok = (px_i < WIN_SIDE) && (pz_i < WIN_SIDE);
    hrd_ok  = (px_i < h_side) && (pz_i < h_side);
    brd_ok  = (px_i < n_side) && (pz_i < n_side);
    host_win_waddr = WIN_AW'(pz_i * WIN_SIDE + px_i);
    host_win_raddr = WIN_AW'((pz_i + 1) * WIN_SIDE + px_i + 1);
    host_pyr_raddr = PYR_AW'(pyr_offset(lv_i) + pz_i * h_side + px_i);
    host_bnd_raddr = BND_AW'(bnd_offset(lv_i) + pz_i * n_side + px_i);
    kind        = K_ZERO;
    err         = 1'b0;
    start       = 1'b0;
    host_win_we = 1'b0;
    host_win_re = 1'b0;
    host_pyr_re = 1'b0;
    host_bnd_re = 1'b0;
    unique case (in_data.req_type)
      REQ_LOAD: begin
        err         = !load_ok;
        host_win_we = acc && load_ok;
      end
      REQ_BUILD: begin
        start = acc;
      end
      REQ_HEIGHT: begin
        err = !hrd_ok;
        if (hrd_ok) begin
          // level zero is the main grid, read straight from the window
          if (lv_i == 0) begin
            kind        = K_WIN;
            host_win_re = acc;
          end else begin
            kind        = K_PYR;
            host_pyr_re = acc;
          end
        end
      end
      REQ_BOUNDS: begin
        err = !brd_ok;
        if (brd_ok) begin
          kind        = K_BND;
          host_bnd_re = acc;
        end
      end
      default: err = 1'b1;
    endcase
  end

  hmmp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  hmmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .win_re    (dp_win_re),
    .win_raddr (dp_win_raddr),
    .win_rdata (win_rdata),
    .pyr_re    (dp_pyr_re),
    .pyr_raddr (dp_pyr_raddr),
    .pyr_rdata (pyr_rdata),
    .pyr_we    (pyr_we),
    .pyr_waddr (pyr_waddr),
    .pyr_wdata (pyr_wdata),
    .bnd_re    (dp_bnd_re),
    .bnd_raddr (dp_bnd_raddr),
    .bnd_rdata (bnd_rdata),
    .bnd_we    (bnd_we),
    .bnd_waddr (bnd_waddr),
    .bnd_wdata (bnd_wdata)
  );

  // the sequencer owns the read ports while busy, the host otherwise
  hmmp_ram #(.DW(SMP_W), .DEPTH(WIN_DEPTH)) u_win_ram (
    .clk   (clk),
    .we    (host_win_we),
    .waddr (host_win_waddr),
    .wdata (in_data.sample),
    .re    (dp_win_re || host_win_re),
    .raddr (busy ? dp_win_raddr : host_win_raddr),
    .rdata (win_rdata)
  );

  hmmp_ram #(.DW(SMP_W), .DEPTH(PYR_DEPTH)) u_pyr_ram (
    .clk   (clk),
    .we    (pyr_we),
    .waddr (pyr_waddr),
    .wdata (pyr_wdata),
    .re    (dp_pyr_re || host_pyr_re),
    .raddr (busy ? dp_pyr_raddr : host_pyr_raddr),
    .rdata (pyr_rdata)
  );

  hmmp_ram #(.DW(2 * SMP_W), .DEPTH(BND_DEPTH)) u_bnd_ram (
    .clk   (clk),
    .we    (bnd_we),
    .waddr (bnd_waddr),
    .wdata (bnd_wdata),
    .re    (dp_bnd_re || host_bnd_re),
    .raddr (busy ? dp_bnd_raddr : host_bnd_raddr),
    .rdata (bnd_rdata)
  );

  // response from the read stage; ram data holds while the stage waits
  always_comb begin
    rsp.status     = s1_err_r;
    rsp.height_out = (s1_kind_r == K_WIN) ? win_rdata :
                     (s1_kind_r == K_PYR) ? pyr_rdata : 8'd0;
    rsp.min_out    = (s1_kind_r == K_BND) ? bnd_rdata[7:0] : 8'd0;
    rsp.max_out    = (s1_kind_r == K_BND) ? bnd_rdata[15:8] : 8'd0;
  end

  always_comb begin
    s1_v_nxt  = acc ? 1'b1 : (mv ? 1'b0 : s1_v_r);
    out_v_nxt = mv ? 1'b1 : (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r <= kind;
      s1_err_r  <= err;
    end
    if (mv) out_r <= rsp;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // a build beat must hand the stores to the sequencer
  `HMMP_ASSERT(a_build_goes_busy, clk, rst_n, (acc && in_data.req_type == REQ_BUILD) |=> busy)
  // pyramid and bounds stores are only written by a running build
  `HMMP_ASSERT(a_store_write_in_build, clk, rst_n, (pyr_we || bnd_we) |-> busy)
  // no sample load may land while the build reads the window
  `HMMP_NEVER(a_no_load_in_build, clk, rst_n, host_win_we && busy)
endmodule

@@ tb/tb_heightmap_mip_minmax_pyramid_top.sv @@
// testbench for heightmap_mip_minmax_pyramid_top: fills the sample window, builds the
// pyramid and quadtree, then checks directed and random reads against an in-bench predictor
// depends on hmmp_pkg and the block's rtl
module tb_heightmap_mip_minmax_pyramid_top;
  import hmmp_pkg::*;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;
  localparam int   CYCLE_LIMIT = 1000000;
  localparam int   RAND_ITEMS  = 1050;

  typedef struct {
    hmmp_req_t req;
    bit        typed;   // expected response typed in below
    hmmp_rsp_t rsp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  hmmp_req_t in_data;
  logic out_valid;
  logic out_stall;
  hmmp_rsp_t out_data;

  heightmap_mip_minmax_pyramid_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state: window samples, pyramid levels 1 and up, node bounds
  logic [7:0] win_smp [0:WIN_SIDE-1][0:WIN_SIDE-1];
  logic [7:0] mip_cell [1:ALL_LEVELS-1][0:GRID_SIDE-1][0:GRID_SIDE-1];
  logic [7:0] node_lo [0:REGION_LEVELS-1][0:REGION_CHUNKS-1][0:REGION_CHUNKS-1];
  logic [7:0] node_hi [0:REGION_LEVELS-1][0:REGION_CHUNKS-1][0:REGION_CHUNKS-1];

  hmmp_rsp_t pending_rsp[$];
  int  errors = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  builds = 0;
  int  err_rsps = 0;
  int  cycles = 0;
  bit  quiet = 0;        // no idling on either side
  int  hold_off = 0;     // receiver long stall, in cycles

  // clock: period 8
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int cells_per_side(int l);
    if (l < REGION_LEVELS) return (REGION_CHUNKS >> l) * CHUNK_CELLS;
    if (l < ALL_LEVELS) return CHUNK_CELLS >> (l - REGION_LEVELS + 1);
    return 0;
  endfunction

  function automatic int nodes_per_side(int l);
    if (l < REGION_LEVELS) return REGION_CHUNKS >> l;
    return 0;
  endfunction

  // a cell of any level, missing parents count as zero
  function automatic int cell_val(int l, int x, int z);
    if (x >= cells_per_side(l) || z >= cells_per_side(l)) return 0;
    if (l == 0) return win_smp[z+1][x+1];
    return mip_cell[l][z][x];
  endfunction

  function automatic void rebuild_stores();
    int s;
    int lo;
    int hi;
    int h;
    for (int l = 1; l < ALL_LEVELS; l++) begin
      for (int z = 0; z < cells_per_side(l); z++) begin
        for (int x = 0; x < cells_per_side(l); x++) begin
          s = cell_val(l-1, 2*x, 2*z) + cell_val(l-1, 2*x+1, 2*z)
            + cell_val(l-1, 2*x, 2*z+1) + cell_val(l-1, 2*x+1, 2*z+1) + 2;
          mip_cell[l][z][x] = 8'(s >> 2);
        end
      end
    end
    for (int l = 0; l < REGION_LEVELS; l++) begin
      for (int z = 0; z < nodes_per_side(l); z++) begin
        for (int x = 0; x < nodes_per_side(l); x++) begin
          lo = 255;
          hi = 0;
          if (l == 0) begin
            // chunk window includes one pad row/col before and two after
            for (int j = 0; j < CHUNK_CELLS + 3; j++) begin
              for (int i = 0; i < CHUNK_CELLS + 3; i++) begin
                h = win_smp[z*CHUNK_CELLS+j][x*CHUNK_CELLS+i];
                if (h < lo) lo = h;
                if (h > hi) hi = h;
              end
            end
          end else begin
            for (int j = 0; j < 2; j++) begin
              for (int i = 0; i < 2; i++) begin
                if (node_lo[l-1][2*z+j][2*x+i] < lo) lo = node_lo[l-1][2*z+j][2*x+i];
                if (node_hi[l-1][2*z+j][2*x+i] > hi) hi = node_hi[l-1][2*z+j][2*x+i];
              end
            end
          end
          node_lo[l][z][x] = 8'(lo);
          node_hi[l][z][x] = 8'(hi);
        end
      end
    end
  endfunction

  // applies one request to the predictor state and returns its response
  function automatic hmmp_rsp_t predict_rsp(hmmp_req_t r);
    hmmp_rsp_t p;
    p = '0;
    case (r.req_type)
      REQ_LOAD: begin
        if (r.pos_x < WIN_SIDE && r.pos_z < WIN_SIDE) win_smp[r.pos_z][r.pos_x] = r.sample;
        else p.status = ST_ERR;
      end
      REQ_BUILD: rebuild_stores();
      REQ_HEIGHT: begin
        if (r.pos_x < cells_per_side(r.level) && r.pos_z < cells_per_side(r.level))
          p.height_out = 8'(cell_val(r.level, r.pos_x, r.pos_z));
        else p.status = ST_ERR;
      end
      default: begin
        if (r.pos_x < nodes_per_side(r.level) && r.pos_z < nodes_per_side(r.level)) begin
          p.min_out = node_lo[r.level][r.pos_z][r.pos_x];
          p.max_out = node_hi[r.level][r.pos_z][r.pos_x];
        end else p.status = ST_ERR;
      end
    endcase
    return p;
  endfunction

  function automatic hmmp_req_t mk_req(logic [1:0] t, int lv, int x, int z, int smp);
    hmmp_req_t r;
    r.req_type = t;
    r.level = 3'(lv);
    r.pos_x = 8'(x);
    r.pos_z = 8'(z);
    r.sample = 8'(smp);
    return r;
  endfunction

  // offers one beat from the falling edge and returns once it is taken;
  // the expectation is queued at the accepting edge
  task automatic send_beat(hmmp_req_t r, bit typed, hmmp_rsp_t typed_rsp);
    hmmp_rsp_t p;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_rsp(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    beats_in++;
    if (r.req_type == REQ_BUILD) builds++;
  endtask

  // receiver: random stalls, a quiet stretch, and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 13);
    end
  end

  // response checker, field by field against the oldest expectation
  always @(posedge clk) begin
    hmmp_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response %p", $time, out_data);
      end else begin
        e = pending_rsp.pop_front();
        if (e.status == ST_ERR) err_rsps++;
        if (out_data.status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
        end
        if (out_data.height_out !== e.height_out) begin
          errors++;
          $display("%0t: height expected %0d actual %0d", $time, e.height_out,
                   out_data.height_out);
        end
        if (out_data.min_out !== e.min_out) begin
          errors++;
          $display("%0t: min expected %0d actual %0d", $time, e.min_out, out_data.min_out);
        end
        if (out_data.max_out !== e.max_out) begin
          errors++;
          $display("%0t: max expected %0d actual %0d", $time, e.max_out, out_data.max_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_heightmap_mip_minmax_pyramid_top failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    hmmp_rsp_t ok_zero;
    hmmp_rsp_t err_zero;
    hmmp_req_t r;
    int pick;
    int lv;
    int side;
    int drain;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    ok_zero = '0;
    err_zero = '0;
    err_zero.status = ST_ERR;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole window so that every build reads written samples;
    // the first and last corners get the extreme heights
    for (int z = 0; z < WIN_SIDE; z++) begin
      for (int x = 0; x < WIN_SIDE; x++) begin
        pick = $urandom_range(0, 255);
        if (x == 0 && z == 0) pick = 0;
        if (x == WIN_SIDE-1 && z == WIN_SIDE-1) pick = 255;
        send_beat(mk_req(REQ_LOAD, $urandom_range(0, 7), x, z, pick), 0, ok_zero);
      end
    end

    // directed table: extremes, every request type, out of range cases
    rows.push_back('{mk_req(REQ_LOAD, 0, WIN_SIDE, 0, 8'hAA), 1, err_zero});
    rows.push_back('{mk_req(REQ_LOAD, 7, 255, 255, 8'h55), 1, err_zero});
    rows.push_back('{mk_req(REQ_LOAD, 0, 5, WIN_SIDE, 8'hFF), 1, err_zero});
    rows.push_back('{mk_req(REQ_BUILD, 0, 0, 0, 0), 1, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 0, 0, 0, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 0, GRID_SIDE-1, GRID_SIDE-1, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 0, GRID_SIDE, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 1, 63, 63, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 3, 15, 0, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 4, 7, 7, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 5, 3, 3, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 5, 4, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, ALL_LEVELS, 0, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 7, 0, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, 0, 0, 0, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, 0, 7, 7, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, 3, 0, 0, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, 3, 1, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, 0, 8, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, REGION_LEVELS, 0, 0, 0), 1, err_zero});
    rows.push_back('{mk_req(REQ_LOAD, 0, 1, 1, 255), 1, ok_zero});
    rows.push_back('{mk_req(REQ_HEIGHT, 0, 0, 0, 0), 0, ok_zero});
    rows.push_back('{mk_req(REQ_LOAD, 0, 1, 1, 0), 1, ok_zero});
    rows.push_back('{mk_req(REQ_BUILD, 0, 0, 0, 0), 1, ok_zero});
    rows.push_back('{mk_req(REQ_BOUNDS, 3, 0, 0, 0), 0, ok_zero});
    foreach (rows[i]) send_beat(rows[i].req, rows[i].typed, rows[i].rsp);

    // random mix; two rebuilds, a quiet stretch and a long receiver hold-off
    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= 500 && n < 650);
      if (n == 300) hold_off = 200;
      if (n == 350 || n == 800) begin
        r = mk_req(REQ_BUILD, $urandom_range(0, 7), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        pick = $urandom_range(0, 99);
        lv = $urandom_range(0, 7);
        if (pick < 35) begin
          // loads, mostly in range
          side = ($urandom_range(0, 9) == 0) ? 256 : WIN_SIDE;
          r = mk_req(REQ_LOAD, lv, $urandom_range(0, side-1), $urandom_range(0, side-1),
                     $urandom_range(0, 255));
        end else if (pick < 75) begin
          if ($urandom_range(0, 9) != 0 && lv >= ALL_LEVELS) lv = $urandom_range(0, ALL_LEVELS-1);
          side = cells_per_side(lv);
          if (side == 0 || $urandom_range(0, 9) == 0) side = 256;
          r = mk_req(REQ_HEIGHT, lv, $urandom_range(0, side-1), $urandom_range(0, side-1),
                     $urandom_range(0, 255));
        end else begin
          if ($urandom_range(0, 9) != 0 && lv >= REGION_LEVELS)
            lv = $urandom_range(0, REGION_LEVELS-1);
          side = nodes_per_side(lv);
          if (side == 0 || $urandom_range(0, 9) == 0) side = 256;
          r = mk_req(REQ_BOUNDS, lv, $urandom_range(0, side-1), $urandom_range(0, side-1),
                     $urandom_range(0, 255));
        end
      end
      send_beat(r, 0, ok_zero);
    end
    quiet = 0;
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then wait on for any stray response
    drain = 0;
    while (pending_rsp.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d request beats, %0d responses, %0d builds, %0d error responses",
             beats_in, beats_out, builds, err_rsps);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("tb_heightmap_mip_minmax_pyramid_top passed");
    end else begin
      $display("%0d mismatches, %0d responses missing", errors, pending_rsp.size());
      $display("tb_heightmap_mip_minmax_pyramid_top failed");
    end
    $finish;
  end

endmodule
